// File: rtl/iba_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the indexed block allocator.
// Used by iba_ctrl, iba_dpath, indexed_block_allocator and iba_checker.
package iba_pkg;

  localparam int DEF_NUM_BLOCKS      = 64;
  localparam int DEF_NUM_SLOTS       = 16;
  localparam int DEF_MAX_FILE_BLOCKS = 8;
  localparam int DEF_BLOCK_BYTES     = 64;

  localparam int SIZE_W = 16;

  localparam logic CMD_CREATE = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_DIR_FULL  = 3'd1;
  localparam logic [2:0] ST_TOO_LARGE = 3'd2;
  localparam logic [2:0] ST_NO_BLOCKS = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  typedef struct packed {
    logic              command;
    logic [63:0]       name_key;
    logic [SIZE_W-1:0] size_bytes;
  } in_item_t;

  typedef struct packed {
    logic [2:0] status;
    logic [3:0] slot_id;
    logic [5:0] index_block_num;
    logic [3:0] data_block_count;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CALC,
    S_POP_IB,
    S_POP_DATA,
    S_COMMIT,
    S_SCAN,
    S_FETCH,
    S_PUSH,
    S_RESP
  } ctl_state_t;

  typedef struct packed {
    logic       capture;
    logic       calc_step;
    logic       pop_ib;
    logic       pop_data;
    logic       commit;
    logic       scan_step;
    logic       scan_hit;
    logic       push_data;
    logic       push_ib;
    logic       load_err;
    logic [2:0] err_code;
  } dp_cmd_t;

  typedef struct packed {
    logic in_is_delete;
    logic size_covered;
    logic blk_at_max;
    logic dir_full;
    logic no_blocks;
    logic data_done;
    logic scan_hit;
    logic scan_last;
  } dp_sts_t;

endpackage

// File: rtl/iba_ctrl.sv
`timescale 1ns / 1ps
// Command sequencer for the indexed block allocator.
// Depends on iba_pkg; drives iba_dpath through dp_cmd_t / dp_sts_t.
module iba_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  iba_pkg::dp_sts_t sts,
  output iba_pkg::dp_cmd_t cmd
);
  import iba_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = sts.in_is_delete ? S_SCAN : S_CALC;
      end
      S_CALC: begin
        if (sts.size_covered) begin
          if (sts.dir_full || sts.no_blocks) state_nxt = S_RESP;
          else                               state_nxt = S_POP_IB;
        end else if (sts.blk_at_max) begin
          state_nxt = S_RESP;
        end
      end
      S_POP_IB:   state_nxt = S_POP_DATA;
      S_POP_DATA: if (sts.data_done) state_nxt = S_COMMIT;
      S_COMMIT:   state_nxt = S_RESP;
      S_SCAN: begin
        if (sts.scan_hit)       state_nxt = S_FETCH;
        else if (sts.scan_last) state_nxt = S_RESP;
      end
      S_FETCH:    state_nxt = S_PUSH;
      S_PUSH:     if (sts.data_done) state_nxt = S_RESP;
      S_RESP:     if (out_ready) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd       = '0;
    in_ready  = 1'b0;
    out_valid = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready    = 1'b1;
        cmd.capture = in_valid;
      end
      S_CALC: begin
        if (sts.size_covered) begin
          if (sts.dir_full) begin
            cmd.load_err = 1'b1;
            cmd.err_code = ST_DIR_FULL;
          end else if (sts.no_blocks) begin
            cmd.load_err = 1'b1;
            cmd.err_code = ST_NO_BLOCKS;
          end else begin
            cmd.pop_ib = 1'b1;
          end
        end else if (sts.blk_at_max) begin
          cmd.load_err = 1'b1;
          cmd.err_code = sts.dir_full ? ST_DIR_FULL : ST_TOO_LARGE;
        end else begin
          cmd.calc_step = 1'b1;
        end
      end
      S_POP_IB:   ;
      S_POP_DATA: cmd.pop_data = !sts.data_done;
      S_COMMIT:   cmd.commit = 1'b1;
      S_SCAN: begin
        if (sts.scan_hit) begin
          cmd.scan_hit = 1'b1;
        end else if (sts.scan_last) begin
          cmd.load_err = 1'b1;
          cmd.err_code = ST_NOT_FOUND;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_FETCH:    ;
      S_PUSH: begin
        if (sts.data_done) cmd.push_ib   = 1'b1;
        else               cmd.push_data = 1'b1;
      end
      S_RESP:     out_valid = 1'b1;
      default:    ;
    endcase
  end

endmodule

// File: rtl/iba_dpath.sv
`timescale 1ns / 1ps
// Datapath: free-block FIFO, directory slots, index store and result register.
// Depends on iba_pkg; sequenced by iba_ctrl.
module iba_dpath #(
  parameter int NUM_BLOCKS      = iba_pkg::DEF_NUM_BLOCKS,
  parameter int NUM_SLOTS       = iba_pkg::DEF_NUM_SLOTS,
  parameter int MAX_FILE_BLOCKS = iba_pkg::DEF_MAX_FILE_BLOCKS,
  parameter int BLOCK_BYTES     = iba_pkg::DEF_BLOCK_BYTES
) (
  input  logic              clk,
  input  logic              rst_n,
  input  iba_pkg::in_item_t in_data,
  input  iba_pkg::dp_cmd_t  cmd,
  output iba_pkg::dp_sts_t  sts,
  output iba_pkg::out_item_t out_data
);
  import iba_pkg::*;

  localparam int BW    = $clog2(NUM_BLOCKS);
  localparam int CNTW  = $clog2(NUM_BLOCKS + 1);
  localparam int SW    = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int FW    = $clog2(NUM_SLOTS + 1);
  localparam int CW    = $clog2(MAX_FILE_BLOCKS + 1);
  localparam int IDEP  = NUM_BLOCKS * MAX_FILE_BLOCKS;
  localparam int IW    = (IDEP > 1) ? $clog2(IDEP) : 1;
  localparam int AMAX  = MAX_FILE_BLOCKS * BLOCK_BYTES;
  localparam int AW0   = $clog2(AMAX + 1);
  localparam int AW    = (AW0 > SIZE_W) ? AW0 : SIZE_W;

  // request latch
  logic              cmd_is_del_r;
  logic [63:0]       key_r;
  logic [SIZE_W-1:0] size_r;

  logic [AW-1:0]     acc_r;
  logic [CW-1:0]     blk_r;
  logic [CW-1:0]     i_r;
  logic [BW-1:0]     ib_r;
  logic [SW-1:0]     slot_sel_r;
  logic [SW-1:0]     sc_r, sc_nxt;

  // free-block FIFO
  logic [BW-1:0]     fifo_mem [NUM_BLOCKS];
  logic              fifo_vld_r [NUM_BLOCKS];
  logic [BW-1:0]     head_r, tail_r, head_nxt, tail_inc;
  logic [CNTW-1:0]   fcount_r;
  logic [BW-1:0]     rd_mem_r, rd_idx_r, head_blk;
  logic              rd_dflt_r;
  logic              pop, push_req, push_en;
  logic [BW-1:0]     push_blk;

  // directory
  logic              slot_used_r [NUM_SLOTS];
  logic [FW-1:0]     file_count_r;
  logic [63:0]       name_mem [NUM_SLOTS];
  logic [BW-1:0]     sib_mem [NUM_SLOTS];
  logic [CW-1:0]     scnt_mem [NUM_SLOTS];
  logic [63:0]       name_rd_r;
  logic [BW-1:0]     sib_rd_r;
  logic [CW-1:0]     scnt_rd_r;
  logic [SW-1:0]     free_idx;
  logic              any_free;

  // index store
  logic [BW-1:0]     idx_mem [IDEP];
  logic [BW-1:0]     idx_rd_r;
  logic [IW-1:0]     idx_waddr, idx_raddr;
  logic [CW-1:0]     idx_ptr;

  out_item_t         res_r;

  assign pop      = cmd.pop_ib | cmd.pop_data;
  assign push_req = cmd.push_data | cmd.push_ib;
  assign push_en  = push_req && (int'(fcount_r) < NUM_BLOCKS);
  assign push_blk = cmd.push_ib ? ib_r : idx_rd_r;
  assign head_nxt = !pop ? head_r : ((int'(head_r) == NUM_BLOCKS - 1) ? '0 : head_r + 1'b1);
  assign tail_inc = (int'(tail_r) == NUM_BLOCKS - 1) ? '0 : tail_r + 1'b1;
  assign head_blk = rd_dflt_r ? rd_idx_r : rd_mem_r;

  always_comb begin
    sc_nxt = sc_r;
    if (cmd.capture)        sc_nxt = '0;
    else if (cmd.scan_step) sc_nxt = sc_r + 1'b1;
  end

  always_comb begin
    any_free = 1'b0;
    free_idx = '0;
    for (int k = NUM_SLOTS - 1; k >= 0; k--) begin
      if (!slot_used_r[k]) begin
        any_free = 1'b1;
        free_idx = SW'(k);
      end
    end
  end

  assign idx_ptr   = cmd.push_data ? i_r + 1'b1 : '0;
  assign idx_waddr = IW'(IW'(ib_r) * IW'(MAX_FILE_BLOCKS) + IW'(i_r));
  assign idx_raddr = IW'(IW'(ib_r) * IW'(MAX_FILE_BLOCKS) + IW'(idx_ptr));

  always_comb begin
    sts              = '0;
    sts.in_is_delete = (in_data.command == CMD_DELETE);
    sts.size_covered = (acc_r >= AW'(size_r));
    sts.blk_at_max   = (int'(blk_r) >= MAX_FILE_BLOCKS);
    sts.dir_full     = (int'(file_count_r) >= NUM_SLOTS) || !any_free;
    sts.no_blocks    = int'(fcount_r) < int'(blk_r) + 1;
    sts.data_done    = (i_r == blk_r);
    sts.scan_hit     = slot_used_r[sc_r] && (name_rd_r == key_r) && cmd_is_del_r;
    sts.scan_last    = (int'(sc_r) == NUM_SLOTS - 1);
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      tail_r       <= '0;
      fcount_r     <= CNTW'(NUM_BLOCKS);
      file_count_r <= '0;
      for (int k = 0; k < NUM_BLOCKS; k++) fifo_vld_r[k] <= 1'b0;
      for (int k = 0; k < NUM_SLOTS; k++)  slot_used_r[k] <= 1'b0;
    end else begin
      head_r <= head_nxt;
      if (pop) fcount_r <= fcount_r - 1'b1;
      if (push_en) begin
        fifo_vld_r[tail_r] <= 1'b1;
        tail_r             <= tail_inc;
        fcount_r           <= fcount_r + 1'b1;
      end
      if (cmd.commit) begin
        slot_used_r[slot_sel_r] <= 1'b1;
        file_count_r            <= file_count_r + 1'b1;
      end
      if (cmd.push_ib) begin
        slot_used_r[slot_sel_r] <= 1'b0;
        if (file_count_r != '0) file_count_r <= file_count_r - 1'b1;
      end
    end
  end

  // FIFO storage; hold the head entry registered, forward a push to the head
  always_ff @(posedge clk) begin
    if (push_en) fifo_mem[tail_r] <= push_blk;
    rd_mem_r <= fifo_mem[head_nxt];
    if (push_en && tail_r == head_nxt) begin
      rd_dflt_r <= 1'b1;
      rd_idx_r  <= push_blk;
    end else begin
      rd_dflt_r <= !fifo_vld_r[head_nxt];
      rd_idx_r  <= head_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      name_mem[slot_sel_r] <= key_r;
      sib_mem[slot_sel_r]  <= ib_r;
      scnt_mem[slot_sel_r] <= blk_r;
    end
    name_rd_r <= name_mem[sc_nxt];
    sib_rd_r  <= sib_mem[sc_nxt];
    scnt_rd_r <= scnt_mem[sc_nxt];
  end

  always_ff @(posedge clk) begin
    if (cmd.pop_data) idx_mem[idx_waddr] <= head_blk;
    idx_rd_r <= idx_mem[idx_raddr];
  end

  // payload
  always_ff @(posedge clk) begin
    sc_r <= sc_nxt;
    if (cmd.capture) begin
      cmd_is_del_r <= in_data.command;
      key_r        <= in_data.name_key;
      size_r       <= in_data.size_bytes;
      acc_r        <= '0;
      blk_r        <= '0;
    end
    if (cmd.calc_step) begin
      acc_r <= acc_r + AW'(BLOCK_BYTES);
      blk_r <= blk_r + 1'b1;
    end
    if (cmd.pop_ib) begin
      ib_r       <= head_blk;
      i_r        <= '0;
      slot_sel_r <= free_idx;
    end
    if (cmd.pop_data || cmd.push_data) i_r <= i_r + 1'b1;
    if (cmd.scan_hit) begin
      slot_sel_r <= sc_r;
      ib_r       <= sib_rd_r;
      blk_r      <= scnt_rd_r;
      i_r        <= '0;
    end
    if (cmd.commit || cmd.push_ib) begin
      res_r.status           <= ST_OK;
      res_r.slot_id          <= 4'(slot_sel_r);
      res_r.index_block_num  <= 6'(ib_r);
      res_r.data_block_count <= 4'(blk_r);
    end
    if (cmd.load_err) begin
      res_r.status           <= cmd.err_code;
      res_r.slot_id          <= '0;
      res_r.index_block_num  <= '0;
      res_r.data_block_count <= '0;
    end
  end

  assign out_data = res_r;

endmodule

// File: rtl/indexed_block_allocator.sv
`timescale 1ns / 1ps
// Indexed block allocator: create/delete over a free-block FIFO and a slot directory.
// One item in flight; the next item can be taken in the cycle after its result leaves.
// Create of B data blocks: size count, index pop, B data pops and commit, then the
// result; a refused create answers after the size count. Delete scans slots up to the
// hit, then frees its B data blocks and index block; an unknown name scans every slot.
// Synchronous active-low reset empties the directory; unwritten FIFO entries read as
// their own index through per-entry valid bits, so there is no clearing pass.
module indexed_block_allocator #(
  parameter int NUM_BLOCKS      = iba_pkg::DEF_NUM_BLOCKS,
  parameter int NUM_SLOTS       = iba_pkg::DEF_NUM_SLOTS,
  parameter int MAX_FILE_BLOCKS = iba_pkg::DEF_MAX_FILE_BLOCKS,
  parameter int BLOCK_BYTES     = iba_pkg::DEF_BLOCK_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  iba_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output iba_pkg::out_item_t out_data
);
  import iba_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  iba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  iba_dpath #(
    .NUM_BLOCKS      (NUM_BLOCKS),
    .NUM_SLOTS       (NUM_SLOTS),
    .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS),
    .BLOCK_BYTES     (BLOCK_BYTES)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

endmodule

// File: rtl/iba_checker.sv
`timescale 1ns / 1ps
// Port-level checks for indexed_block_allocator, attached by bind.
// Depends on iba_pkg.
module iba_assertions #(
  parameter int MAX_FILE_BLOCKS = iba_pkg::DEF_MAX_FILE_BLOCKS
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input iba_pkg::out_item_t out_data
);
  import iba_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input taken while a result waits");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |->
      out_data.slot_id == 4'd0 && out_data.index_block_num == 6'd0 &&
      out_data.data_block_count == 4'd0)
    else $error("error result carries data");

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(out_data.data_block_count) <= MAX_FILE_BLOCKS)
    else $error("block count above limit");

  a_accept_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !out_valid)
    else $error("result appeared right after accept");

endmodule

bind indexed_block_allocator iba_assertions #(
  .MAX_FILE_BLOCKS (MAX_FILE_BLOCKS)
) u_iba_assertions (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
